### design/skl_pkg.sv
// package: sizes and control types shared by the k-th largest selector
package skl_pkg;

  localparam int RANK_MAX   = 64;
  localparam int VALUE_BITS = 32;
  localparam int RANK_BITS  = 7;
  localparam int CNT_BITS   = $clog2(RANK_MAX + 1);
  localparam int IDX_BITS   = (RANK_MAX > 1) ? $clog2(RANK_MAX) : 1;

  // register index, decoded from paddr[2]
  localparam logic REG_RANK_K = 1'b0;

  typedef struct packed {
    logic step;
    logic last;
    logic shift;
    logic capture;
  } skl_cmd_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] sel_idx;
  } skl_status_t;

endpackage

### design/stream_kth_largest.sv
// top level: k-th largest of each set of signed words, with rank register
// throughput: one word per cycle inside a set; the last word of a set then
// blocks input while the sorted chain shifts the answer to its head by j places,
// j being the number of kept values minus one (at most rank-1), and until it is captured
// result: taken from the chain head once the output register is free
// reset: rank reads 1, the kept-value count is zero, the value chain is not cleared
module stream_kth_largest (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [2:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [skl_pkg::VALUE_BITS-1:0]  sample_value_i,
  input  logic                                   set_last_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [skl_pkg::VALUE_BITS-1:0]  kth_value_o,
  output logic                                   short_set_o
);
  import skl_pkg::*;

  logic [RANK_BITS-1:0] rank_k_q;
  skl_cmd_t             cmd;
  skl_status_t          status;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_k_q <= RANK_BITS'(1);
    end else if (wr_en && (paddr[2] == REG_RANK_K)) begin
      rank_k_q <= pwdata[RANK_BITS-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RANK_K: prdata = {{(32 - RANK_BITS){1'b0}}, rank_k_q};
      default:    prdata = '0;
    endcase
  end

  skl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .set_last_i  (set_last_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  skl_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rank_k_i       (rank_k_q),
    .sample_value_i (sample_value_i),
    .status_o       (status),
    .kth_value_o    (kth_value_o),
    .short_set_o    (short_set_o)
  );

endmodule

### design/skl_ctrl.sv
// controller: word acceptance, shift-out sequencing and result handshake
module skl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                set_last_i,
  input  logic                out_stall_i,
  input  skl_pkg::skl_status_t status_i,
  output skl_pkg::skl_cmd_t   cmd_o,
  output logic                in_stall_o,
  output logic                out_valid_o
);
  import skl_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SHIFT
  } state_e;

  state_e              state_q, state_d;
  logic [IDX_BITS-1:0] cnt_q, cnt_d;
  logic                stall_q, stall_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;
  logic                out_free;

  assign accept   = in_valid_i && !stall_q;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o.step    = accept;
    cmd_o.last    = set_last_i;
    cmd_o.shift   = (state_q == S_SHIFT) && (cnt_q != '0);
    cmd_o.capture = (state_q == S_SHIFT) && (cnt_q == '0) && out_free;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    stall_d     = stall_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (accept && set_last_i) begin
          state_d = S_SHIFT;
          cnt_d   = status_i.sel_idx;
          stall_d = 1'b1;
        end
      end
      S_SHIFT: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - IDX_BITS'(1);
        end else if (out_free) begin
          state_d     = S_IDLE;
          stall_d     = 1'b0;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
        stall_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      stall_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      stall_q     <= stall_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = stall_q;
  assign out_valid_o = out_valid_q;

endmodule

### design/skl_dp.sv
// datapath: sorted insertion chain of kept values, held count and result registers
module skl_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  skl_pkg::skl_cmd_t                      cmd_i,
  input  logic [skl_pkg::RANK_BITS-1:0]          rank_k_i,
  input  logic signed [skl_pkg::VALUE_BITS-1:0]  sample_value_i,
  output skl_pkg::skl_status_t                   status_o,
  output logic signed [skl_pkg::VALUE_BITS-1:0]  kth_value_o,
  output logic                                   short_set_o
);
  import skl_pkg::*;

  logic signed [VALUE_BITS-1:0] cell_q [RANK_MAX];
  logic signed [VALUE_BITS-1:0] cell_d [RANK_MAX];
  logic [RANK_MAX-1:0]          gt;
  logic [CNT_BITS-1:0]          held_q, held_d;
  logic [CNT_BITS-1:0]          k, n, m, n_after, k_m1;
  logic                         gt_km1, do_ins;
  logic                         short_pend_q;
  logic signed [VALUE_BITS-1:0] kth_q;
  logic                         short_q;

  // effective rank, clamped to 1..RANK_MAX
  always_comb begin
    if (rank_k_i == '0) begin
      k = CNT_BITS'(1);
    end else if (int'(rank_k_i) > RANK_MAX) begin
      k = CNT_BITS'(RANK_MAX);
    end else begin
      k = CNT_BITS'(rank_k_i);
    end
  end

  assign k_m1 = k - CNT_BITS'(1);
  assign n    = (held_q > k) ? k : held_q;

  always_comb begin
    gt_km1 = 1'b0;
    for (int i = 0; i < RANK_MAX; i++) begin
      gt[i] = sample_value_i > cell_q[i];
      if (CNT_BITS'(i) == k_m1) begin
        gt_km1 = gt[i];
      end
    end
  end

  assign do_ins  = (n < k) || gt_km1;
  assign m       = (n < k) ? n : k_m1;
  assign n_after = (n < k) ? (n + CNT_BITS'(1)) : k;
  assign held_d  = cmd_i.last ? '0 : n_after;

  // each cell keeps, takes the new word, or takes its upper neighbor
  always_comb begin
    for (int i = 0; i < RANK_MAX; i++) begin
      cell_d[i] = cell_q[i];
      if (do_ins) begin
        if ((CNT_BITS'(i) < m) && !gt[i]) begin
          cell_d[i] = cell_q[i];
        end else if (CNT_BITS'(i) <= m) begin
          if (i == 0) begin
            cell_d[i] = sample_value_i;
          end else if (!gt[(i > 0) ? i - 1 : 0]) begin
            cell_d[i] = sample_value_i;
          end else begin
            cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
          end
        end
      end
    end
  end

  assign status_o.sel_idx = IDX_BITS'(n_after - CNT_BITS'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (cmd_i.step) begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      for (int i = 0; i < RANK_MAX; i++) begin
        cell_q[i] <= cell_d[i];
      end
      if (cmd_i.last) begin
        short_pend_q <= (n_after < k);
      end
    end else if (cmd_i.shift) begin
      for (int i = 0; i < RANK_MAX - 1; i++) begin
        cell_q[i] <= cell_q[i + 1];
      end
    end
    if (cmd_i.capture) begin
      kth_q   <= cell_q[0];
      short_q <= short_pend_q;
    end
  end

  assign kth_value_o = kth_q;
  assign short_set_o = short_q;

endmodule
